@@ sv/vertex_transform_3d_defines.svh @@
// Assertion macros for the vertex transform block.
// Used by the port checker; no other dependencies.
`ifndef VERTEX_TRANSFORM_3D_DEFINES_SVH
`define VERTEX_TRANSFORM_3D_DEFINES_SVH

// Checked outside reset
`define VT3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define VT3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/vt3_pkg.sv @@
// Shared types, codes and constants for the vertex transform block.
// No dependencies.
package vt3_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned OffW    = 33;
  localparam int unsigned TrigW   = 18;
  localparam int unsigned FactW   = 24;
  localparam int unsigned OpW     = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WideW   = 72;
  localparam int unsigned QDepth  = 4;

  localparam int unsigned     FRAC_BITS_DEF     = 16;
  localparam logic [31:0]     MOVE_DISTANCE_DEF = 32'd65536;

  typedef enum logic [OpW-1:0] {
    OP_ROTX       = 4'd0,
    OP_ROTY       = 4'd1,
    OP_ROTZ       = 4'd2,
    OP_SCALE_UP   = 4'd3,
    OP_SCALE_DOWN = 4'd4,
    OP_PERSP      = 4'd5,
    OP_MOVE_L     = 4'd6,
    OP_MOVE_R     = 4'd7,
    OP_MOVE_D     = 4'd8,
    OP_MOVE_U     = 4'd9
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_COS_ANGLE   = 3'd3,
    REG_SIN_ANGLE   = 3'd4,
    REG_UP_FACTOR   = 3'd5,
    REG_DOWN_FACTOR = 3'd6,
    REG_PERSP_RECIP = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    K_ROT   = 5'b00001,
    K_SCALE = 5'b00010,
    K_PERSP = 5'b00100,
    K_MOVE  = 5'b01000,
    K_PASS  = 5'b10000
  } kind_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic signed [TrigW-1:0]  cos_a;
    logic signed [TrigW-1:0]  sin_a;
    logic [FactW-1:0]         up_f;
    logic [FactW-1:0]         down_f;
    logic signed [CoordW-1:0] recip;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]           op;
    kind_t                    kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [OffW-1:0]   tx;
    logic signed [OffW-1:0]   ty;
    logic signed [OffW-1:0]   tz;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] val;
    logic              sat;
  } clip_t;

  localparam logic signed [WideW-1:0] WideMax = WideW'(64'sh7fffffff);
  localparam logic signed [WideW-1:0] WideMin = WideW'(-64'sh80000000);

  function automatic clip_t sat32(input logic signed [WideW-1:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[CoordW-1:0];
    if (v > WideMax) begin
      r.val = WideMax[CoordW-1:0];
      r.sat = 1'b1;
    end else if (v < WideMin) begin
      r.val = WideMin[CoordW-1:0];
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ sv/vt3_front.sv @@
// Front end: takes input beats, classifies the opcode, forms pivot offsets.
// Depends on vt3_pkg.
module vt3_front (
  input  logic                    clk,
  input  logic                    rst,
  input  vt3_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              opcode,
  input  logic signed [31:0]      x_in,
  input  logic signed [31:0]      y_in,
  input  logic signed [31:0]      z_in,
  output logic                    push,
  output vt3_pkg::item_t          item,
  input  logic                    q_full
);
  import vt3_pkg::*;

  logic  fv;
  item_t fitem;
  item_t item_next;
  logic  load;

  assign push     = fv && !q_full;
  assign in_stall = fv && q_full;
  assign load     = in_valid && !in_stall;
  assign item     = fitem;

  always_comb begin
    item_next.op = opcode;
    item_next.x  = x_in;
    item_next.y  = y_in;
    item_next.z  = z_in;
    item_next.tx = OffW'(x_in) - OffW'(cfg.cx);
    item_next.ty = OffW'(y_in) - OffW'(cfg.cy);
    item_next.tz = OffW'(z_in) - OffW'(cfg.cz);
    case (opcode)
      OP_ROTX, OP_ROTY, OP_ROTZ:                    item_next.kind = K_ROT;
      OP_SCALE_UP, OP_SCALE_DOWN:                   item_next.kind = K_SCALE;
      OP_PERSP:                                     item_next.kind = K_PERSP;
      OP_MOVE_L, OP_MOVE_R, OP_MOVE_D, OP_MOVE_U:   item_next.kind = K_MOVE;
      default:                                      item_next.kind = K_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fitem <= item_next;
    end
  end

endmodule

@@ sv/vt3_fifo.sv @@
// Short queue between front and back ends.
// Depends on vt3_pkg.
module vt3_fifo #(
  parameter int unsigned DEPTH = vt3_pkg::QDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vt3_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output vt3_pkg::item_t dout,
  output logic           nonempty
);
  import vt3_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem [DEPTH];
  logic [AW-1:0] wr;
  logic [AW-1:0] rd;
  logic [AW:0]   cnt;

  assign full     = cnt == (AW+1)'(DEPTH);
  assign nonempty = cnt != '0;
  assign dout     = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr <= (wr == AW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == AW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= din;
    end
  end

endmodule

@@ sv/vt3_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// No package dependencies.
module vt3_div #(
  parameter int unsigned EW  = 50,
  parameter int unsigned DMW = 48
) (
  input  logic           clk,
  input  logic           adv,
  input  logic [EW-1:0]  dvd,
  input  logic [DMW-1:0] dm,
  output logic [EW-1:0]  quo
);

  logic [DMW-1:0] rem_r [EW];
  logic [EW-1:0]  dvd_r [EW];
  logic [EW-1:0]  quo_r [EW];
  logic [DMW-1:0] dm_r  [EW];

  for (genvar k = 0; k < EW; k++) begin : g_stage
    logic [DMW-1:0] rem_i;
    logic [EW-1:0]  dvd_i;
    logic [EW-1:0]  quo_i;
    logic [DMW-1:0] dm_i;
    logic [DMW:0]   trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign dvd_i = dvd;
      assign quo_i = '0;
      assign dm_i  = dm;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign dvd_i = dvd_r[k-1];
      assign quo_i = quo_r[k-1];
      assign dm_i  = dm_r[k-1];
    end

    assign trial = {rem_i, dvd_i[EW-1]};
    assign take  = trial >= {1'b0, dm_i};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? DMW'(trial - {1'b0, dm_i}) : trial[DMW-1:0];
        dvd_r[k] <= dvd_i << 1;
        quo_r[k] <= {quo_i[EW-2:0], take};
        dm_r[k]  <= dm_i;
      end
    end
  end

  assign quo = quo_r[EW-1];

endmodule

@@ sv/vt3_back.sv @@
// Back end: multiply, round, perspective divide, saturate, output register.
// Depends on vt3_pkg and vt3_div.
module vt3_back #(
  parameter int unsigned FRAC_BITS     = vt3_pkg::FRAC_BITS_DEF,
  parameter logic [31:0] MOVE_DISTANCE = vt3_pkg::MOVE_DISTANCE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vt3_pkg::cfg_t      cfg,
  input  vt3_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic               saturated
);
  import vt3_pkg::*;

  localparam int unsigned VW   = 58;
  localparam int unsigned PPW  = 65;
  localparam int unsigned DMW  = 64 - FRAC_BITS;
  localparam int unsigned NW   = OffW + FRAC_BITS;
  localparam int unsigned EW   = ((NW > DMW) ? NW : DMW) + 1;
  localparam int unsigned Tenth = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic [VW-1:0]          HalfV = VW'(1) << (FRAC_BITS - 1);
  localparam logic [PPW-1:0]         HalfP = PPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PPW-1:0]  OneP  = PPW'(1) << FRAC_BITS;
  localparam logic signed [PPW-1:0]  TenthP = PPW'(Tenth);

  typedef struct packed {
    logic              persp;
    logic              negx;
    logic              negy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              sat;
  } side_t;

  function automatic logic signed [VW-1:0] rnd_v(input logic signed [VW-1:0] v);
    logic [VW-1:0] m;
    m = v[VW-1] ? VW'(-v) : VW'(v);
    m = (m + HalfV) >> FRAC_BITS;
    return v[VW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PPW-1:0] rnd_p(input logic signed [PPW-1:0] v);
    logic [PPW-1:0] m;
    m = v[PPW-1] ? PPW'(-v) : PPW'(v);
    m = (m + HalfP) >> FRAC_BITS;
    return v[PPW-1] ? -$signed(m) : $signed(m);
  endfunction

  logic adv;
  logic vo;

  assign adv       = !vo || !out_stall;
  assign pop       = adv && head_valid;
  assign out_valid = vo;

  // stage 1: products
  logic signed [OffW-1:0]   u_sel;
  logic signed [OffW-1:0]   v_sel;
  logic [FactW-1:0]         fac;
  logic                     v1;
  item_t                    it1;
  logic signed [50:0]       p_uc, p_vs, p_us, p_vc;
  logic signed [VW-1:0]     p_sx, p_sy, p_sz;
  logic signed [48:0]       p_hi;
  logic signed [49:0]       p_lo;

  always_comb begin
    u_sel = head.ty;
    v_sel = head.tz;
    case (head.op)
      OP_ROTY: begin
        u_sel = head.tz;
        v_sel = head.tx;
      end
      OP_ROTZ: begin
        u_sel = head.tx;
        v_sel = head.ty;
      end
      default: begin
        u_sel = head.ty;
        v_sel = head.tz;
      end
    endcase
    fac = (head.op == OP_SCALE_UP) ? cfg.up_f : cfg.down_f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1  <= head;
      p_uc <= u_sel * $signed(cfg.cos_a);
      p_vs <= v_sel * $signed(cfg.sin_a);
      p_us <= u_sel * $signed(cfg.sin_a);
      p_vc <= v_sel * $signed(cfg.cos_a);
      p_sx <= $signed(head.tx) * $signed({1'b0, fac});
      p_sy <= $signed(head.ty) * $signed({1'b0, fac});
      p_sz <= $signed(head.tz) * $signed({1'b0, fac});
      p_hi <= $signed(head.tz) * $signed(cfg.recip[31:16]);
      p_lo <= $signed(head.tz) * $signed({1'b0, cfg.recip[15:0]});
    end
  end

  // stage 2: sums
  logic signed [51:0]   ru, rv;
  logic signed [VW-1:0] vx, vy, vz;
  logic                 v2;
  item_t                it2;
  logic signed [VW-1:0] vx2, vy2, vz2;
  logic signed [PPW-1:0] pp2;

  assign ru = 52'(p_uc) - 52'(p_vs);
  assign rv = 52'(p_us) + 52'(p_vc);

  always_comb begin
    vx = p_sx;
    vy = p_sy;
    vz = p_sz;
    if (it1.kind == K_ROT) begin
      case (it1.op)
        OP_ROTX: begin
          vy = VW'(ru);
          vz = VW'(rv);
        end
        OP_ROTY: begin
          vz = VW'(ru);
          vx = VW'(rv);
        end
        default: begin
          vx = VW'(ru);
          vy = VW'(rv);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2 <= it1;
      vx2 <= vx;
      vy2 <= vy;
      vz2 <= vz;
      pp2 <= (PPW'(p_hi) <<< 16) + PPW'(p_lo);
    end
  end

  // stage 3: rounding
  logic                  v3;
  item_t                 it3;
  logic signed [VW-1:0]  rx3, ry3, rz3;
  logic signed [PPW-1:0] d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it3 <= it2;
      rx3 <= rnd_v(vx2);
      ry3 <= rnd_v(vy2);
      rz3 <= rnd_v(vz2);
      d3  <= OneP + rnd_p(pp2);
    end
  end

  // stage 4: pivot, moves, saturation, divider set-up
  logic signed [WideW-1:0] ex, ey, ez;
  logic signed [WideW-1:0] ax, ay, az;
  logic signed [WideW-1:0] mv;
  clip_t                   cx4, cy4, cz4;
  logic signed [PPW-1:0]   dc;
  logic [PPW-1:0]          dmag;
  logic [DMW-1:0]          dm;
  logic [OffW-1:0]         txm, tym;
  logic [EW-1:0]           dvdx, dvdy;
  logic                    v4;
  logic [EW-1:0]           dvdx4, dvdy4;
  logic [DMW-1:0]          dm4;
  side_t                   side4;

  assign ax = WideW'(rx3) + WideW'(cfg.cx);
  assign ay = WideW'(ry3) + WideW'(cfg.cy);
  assign az = WideW'(rz3) + WideW'(cfg.cz);
  assign mv = $signed(WideW'(MOVE_DISTANCE));

  always_comb begin
    ex = WideW'(it3.x);
    ey = WideW'(it3.y);
    ez = WideW'(it3.z);
    case (it3.kind)
      K_ROT: begin
        case (it3.op)
          OP_ROTX: begin
            ey = ay;
            ez = az;
          end
          OP_ROTY: begin
            ex = ax;
            ez = az;
          end
          default: begin
            ex = ax;
            ey = ay;
          end
        endcase
      end
      K_SCALE: begin
        ex = ax;
        ey = ay;
        ez = az;
      end
      K_MOVE: begin
        case (it3.op)
          OP_MOVE_L: ex = WideW'(it3.x) - mv;
          OP_MOVE_R: ex = WideW'(it3.x) + mv;
          OP_MOVE_D: ey = WideW'(it3.y) - mv;
          default:   ey = WideW'(it3.y) + mv;
        endcase
      end
      default: begin
        ex = WideW'(it3.x);
      end
    endcase
  end

  assign cx4 = sat32(ex);
  assign cy4 = sat32(ey);
  assign cz4 = sat32(ez);

  always_comb begin
    dc = d3;
    if (!d3[PPW-1] && d3 < TenthP) begin
      dc = TenthP;
    end else if (d3[PPW-1] && d3 > -TenthP) begin
      dc = -TenthP;
    end
  end

  assign dmag = dc[PPW-1] ? PPW'(-dc) : PPW'(dc);
  assign dm   = dmag[DMW-1:0];
  assign txm  = it3.tx[OffW-1] ? OffW'(-it3.tx) : OffW'(it3.tx);
  assign tym  = it3.ty[OffW-1] ? OffW'(-it3.ty) : OffW'(it3.ty);
  assign dvdx = (EW'(txm) << FRAC_BITS) + EW'(dm >> 1);
  assign dvdy = (EW'(tym) << FRAC_BITS) + EW'(dm >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvdx4       <= dvdx;
      dvdy4       <= dvdy;
      dm4         <= dm;
      side4.persp <= it3.kind == K_PERSP;
      side4.negx  <= it3.tx[OffW-1] != dc[PPW-1];
      side4.negy  <= it3.ty[OffW-1] != dc[PPW-1];
      side4.x     <= cx4.val;
      side4.y     <= cy4.val;
      side4.z     <= cz4.val;
      side4.sat   <= cx4.sat | cy4.sat | cz4.sat;
    end
  end

  // divider stages
  logic [EW-1:0] qx, qy;
  logic [EW-1:0] pv;
  side_t         side [EW];

  vt3_div #(.EW(EW), .DMW(DMW)) u_div_x (
    .clk (clk),
    .adv (adv),
    .dvd (dvdx4),
    .dm  (dm4),
    .quo (qx)
  );

  vt3_div #(.EW(EW), .DMW(DMW)) u_div_y (
    .clk (clk),
    .adv (adv),
    .dvd (dvdy4),
    .dm  (dm4),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[EW-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side4;
      for (int k = 1; k < EW; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // output register
  side_t                   sl;
  logic signed [WideW-1:0] qxs, qys;
  clip_t                   fx, fy;

  assign sl  = side[EW-1];
  assign qxs = sl.negx ? -$signed(WideW'(qx)) : $signed(WideW'(qx));
  assign qys = sl.negy ? -$signed(WideW'(qy)) : $signed(WideW'(qy));
  assign fx  = sat32(qxs + WideW'(cfg.cx));
  assign fy  = sat32(qys + WideW'(cfg.cy));

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= pv[EW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sl.persp) begin
        x_out     <= fx.val;
        y_out     <= fy.val;
        saturated <= fx.sat | fy.sat;
      end else begin
        x_out     <= sl.x;
        y_out     <= sl.y;
        saturated <= sl.sat;
      end
      z_out <= sl.z;
    end
  end

endmodule

@@ sv/vertex_transform_3d.sv @@
// Top level of the 3D vertex transform block: configuration registers,
// front end, queue and back end. Depends on vt3_pkg, vt3_front, vt3_fifo, vt3_back and vt3_div.
//
// Takes one point per clock and returns one transformed point per clock for
// as long as the output side does not stall. A beat passes the front end, the
// queue, the product, sum, rounding and pivot stages, the two perspective
// dividers, which resolve one quotient bit per pipeline stage and are
// EW = max(33 + FRAC_BITS, 64 - FRAC_BITS) + 1 bits wide, and the output
// register. A four-entry queue sits between the front and back ends. Every
// opcode takes the same path and latency. Configuration writes are always
// accepted and must be made only while no beat is in flight.
module vertex_transform_3d #(
  parameter int unsigned FRAC_BITS     = vt3_pkg::FRAC_BITS_DEF,
  parameter logic [31:0] MOVE_DISTANCE = vt3_pkg::MOVE_DISTANCE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic               saturated
);
  import vt3_pkg::*;

  cfg_t  cfg;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_nonempty;
  item_t f_item;
  item_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx     <= '0;
      cfg.cy     <= '0;
      cfg.cz     <= '0;
      cfg.cos_a  <= 18'sd65536;
      cfg.sin_a  <= '0;
      cfg.up_f   <= 24'd65536;
      cfg.down_f <= 24'd65536;
      cfg.recip  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    cfg.cx     <= cfg_data;
        REG_CENTER_Y:    cfg.cy     <= cfg_data;
        REG_CENTER_Z:    cfg.cz     <= cfg_data;
        REG_COS_ANGLE:   cfg.cos_a  <= cfg_data[TrigW-1:0];
        REG_SIN_ANGLE:   cfg.sin_a  <= cfg_data[TrigW-1:0];
        REG_UP_FACTOR:   cfg.up_f   <= cfg_data[FactW-1:0];
        REG_DOWN_FACTOR: cfg.down_f <= cfg_data[FactW-1:0];
        REG_PERSP_RECIP: cfg.recip  <= cfg_data;
        default:         cfg.recip  <= cfg.recip;
      endcase
    end
  end

  vt3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .x_in     (x_in),
    .y_in     (y_in),
    .z_in     (z_in),
    .push     (push),
    .item     (f_item),
    .q_full   (q_full)
  );

  vt3_fifo #(.DEPTH(QDepth)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_item),
    .full     (q_full),
    .pop      (pop),
    .dout     (q_head),
    .nonempty (q_nonempty)
  );

  vt3_back #(
    .FRAC_BITS     (FRAC_BITS),
    .MOVE_DISTANCE (MOVE_DISTANCE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .head_valid (q_nonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_out      (x_out),
    .y_out      (y_out),
    .z_out      (z_out),
    .saturated  (saturated)
  );

endmodule

@@ sv/vt3_checker.sv @@
// Port checker for the vertex transform block, bound to the top level.
// Depends on vertex_transform_3d_defines.svh.
`include "vertex_transform_3d_defines.svh"

module vt3_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] x_out,
  input logic signed [31:0] y_out,
  input logic signed [31:0] z_out,
  input logic               saturated
);

  `VT3_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "out_valid after reset")
  `VT3_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out), "stalled beat changed")
  `VT3_ASSERT(a_sat_at_limit, out_valid && saturated |-> (x_out == 32'sh7fffffff || x_out == 32'sh80000000 || y_out == 32'sh7fffffff || y_out == 32'sh80000000 || z_out == 32'sh7fffffff || z_out == 32'sh80000000), "saturated without a clipped coordinate")

endmodule

bind vertex_transform_3d vt3_checker u_vt3_checker (.*);
